// ----- sv/assert_macros.svh -----
// assertion macros shared by the scheduler rtl
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- sv/rrts_pkg.sv -----
// shared types and codes for the round-robin thread scheduler
// no dependencies
package rrts_pkg;

  localparam int unsigned IdW = 6;

  localparam logic [1:0] OpCreate = 2'd0;
  localparam logic [1:0] OpTick   = 2'd1;
  localparam logic [1:0] OpExit   = 2'd2;

  localparam logic [2:0] ActNone   = 3'd0;
  localparam logic [2:0] ActStart  = 3'd1;
  localparam logic [2:0] ActResume = 3'd2;
  localparam logic [2:0] ActAccept = 3'd3;
  localparam logic [2:0] ActReject = 3'd4;

  typedef struct packed {
    logic [2:0]     action;
    logic [IdW-1:0] dispatched_thread;
    logic           previous_saved;
    logic [IdW-1:0] previous_thread;
    logic [IdW-1:0] ready_count;
  } result_t;

endpackage

// ----- sv/rrts_ring.sv -----
// ready ring storage: one write port, one read port with registered data
// uses rrts_pkg for the id width
module rrts_ring #(
  parameter int unsigned QUEUE_DEPTH = 64,
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    re_i,
  input  logic [IdxW-1:0]         raddr_i,
  output logic [rrts_pkg::IdW-1:0] rdata_o,
  input  logic                    we_i,
  input  logic [IdxW-1:0]         waddr_i,
  input  logic [rrts_pkg::IdW-1:0] wdata_i
);

  logic [rrts_pkg::IdW-1:0] mem [QUEUE_DEPTH];
  logic [rrts_pkg::IdW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rrts_flags.sv -----
// started flags, one per thread slot, cleared by reset
// uses no package items
module rrts_flags #(
  parameter int unsigned SLOTS = 64,
  localparam int unsigned SlotW = $clog2(SLOTS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SlotW-1:0] rd_slot_i,
  output logic             rd_flag_o,
  input  logic             set_i,
  input  logic [SlotW-1:0] set_slot_i,
  input  logic             clr_i,
  input  logic [SlotW-1:0] clr_slot_i
);

  logic [SLOTS-1:0] flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      if (clr_i) begin
        flags_q[clr_slot_i] <= 1'b0;
      end
      if (set_i) begin
        flags_q[set_slot_i] <= 1'b1;
      end
    end
  end

  assign rd_flag_o = flags_q[rd_slot_i];

endmodule

// ----- sv/round_robin_thread_scheduler_top.sv -----
// round-robin thread scheduler over a circular ready ring held in a synchronous memory
// an accepted beat passes through the execute state, then its registered result raises the strobe; busy is high
// during execute, so no new beat is taken until the last one is through; the ring read is issued on the accept edge,
// the execute cycle does modify and write back; reset clears indices, running thread and started flags at once;
// ring contents stay undefined; depends on rrts_pkg, rrts_ring, rrts_flags and assert_macros.svh
`include "assert_macros.svh"

module round_robin_thread_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned MAX_THREADS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               operation_i,
  input  logic [rrts_pkg::IdW-1:0] thread_id_i,
  output logic                     result_valid_o,
  output logic [2:0]               action_o,
  output logic [rrts_pkg::IdW-1:0] dispatched_thread_o,
  output logic                     previous_saved_o,
  output logic [rrts_pkg::IdW-1:0] previous_thread_o,
  output logic [rrts_pkg::IdW-1:0] ready_count_o
);

  localparam int unsigned IdxW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned NumIds   = 2 ** rrts_pkg::IdW;
  // ids are 6 bits, so at most 64 flag slots are ever reachable
  localparam int unsigned FlagSlots = (MAX_THREADS < NumIds) ? MAX_THREADS : NumIds;
  localparam int unsigned SlotW    = $clog2(FlagSlots);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);

  typedef enum logic {StIdle, StExec} state_e;

  // control state
  state_e                   state_q;
  logic [IdxW-1:0]          wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]          rd_idx_q, rd_idx_d;
  logic                     run_valid_q, run_valid_d;
  logic [rrts_pkg::IdW-1:0] run_id_q, run_id_d;
  logic                     result_valid_q;
  rrts_pkg::result_t        res_q, res_d;

  // latched input beat
  logic [1:0]               op_q;
  logic [rrts_pkg::IdW-1:0] tid_q;

  logic                     accept;
  logic                     exec;
  logic                     ring_empty, ring_full, keep_running;
  logic                     ring_we;
  logic [rrts_pkg::IdW-1:0] ring_wdata, ring_rdata;
  logic                     flag_rd, flag_set, flag_clr;
  logic [CntW-1:0]          cnt_next, cnt_now;

  // id to flag slot: id modulo MAX_THREADS, a constant table
  logic [SlotW-1:0] slot_tab [NumIds];

  for (genvar g = 0; g < NumIds; g++) begin : g_slot
    assign slot_tab[g] = SlotW'(g % MAX_THREADS);
  end

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] i);
    idx_inc = (i == LastIdx) ? '0 : IdxW'(i + 1'b1);
  endfunction

  // entries between read and write index, wrapping at the ring depth
  function automatic logic [CntW-1:0] ring_cnt(input logic [IdxW-1:0] w,
                                               input logic [IdxW-1:0] r);
    logic [CntW-1:0] diff;
    diff = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      diff = diff + CntW'(QUEUE_DEPTH);
    end
    ring_cnt = diff;
  endfunction

  assign busy   = (state_q == StExec);
  assign accept = start && !busy;
  assign exec   = (state_q == StExec);

  assign ring_empty   = (wr_idx_q == rd_idx_q);
  assign ring_full    = (idx_inc(wr_idx_q) == rd_idx_q);
  // an exit drops the running thread before scheduling
  assign keep_running = run_valid_q && (op_q != rrts_pkg::OpExit);
  assign cnt_now      = ring_cnt(wr_idx_q, rd_idx_q);

  // head of ring is read on the accept edge, ready during execute
  rrts_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (rd_idx_q),
    .rdata_o (ring_rdata),
    .we_i    (ring_we),
    .waddr_i (wr_idx_q),
    .wdata_i (ring_wdata)
  );

  rrts_flags #(
    .SLOTS (FlagSlots)
  ) u_flags (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_slot_i  (slot_tab[ring_rdata]),
    .rd_flag_o  (flag_rd),
    .set_i      (flag_set),
    .set_slot_i (slot_tab[ring_rdata]),
    .clr_i      (flag_clr),
    .clr_slot_i (slot_tab[tid_q])
  );

  // execute cycle: read-modify-write of indices, ring and flags
  always_comb begin
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    run_valid_d = run_valid_q;
    run_id_d    = run_id_q;
    ring_we     = 1'b0;
    ring_wdata  = tid_q;
    flag_set    = 1'b0;
    flag_clr    = 1'b0;
    res_d       = '0;
    res_d.action = rrts_pkg::ActNone;
    if (exec) begin
      case (op_q)
        rrts_pkg::OpCreate: begin
          if (ring_full) begin
            res_d.action = rrts_pkg::ActReject;
          end else begin
            ring_we      = 1'b1;
            wr_idx_d     = idx_inc(wr_idx_q);
            flag_clr     = 1'b1;
            res_d.action = rrts_pkg::ActAccept;
          end
        end
        rrts_pkg::OpTick, rrts_pkg::OpExit: begin
          if (op_q == rrts_pkg::OpExit) begin
            run_valid_d = 1'b0;
          end
          if (!ring_empty) begin
            rd_idx_d = idx_inc(rd_idx_q);
            // requeue the thread being switched out at the tail
            if (keep_running) begin
              ring_we               = 1'b1;
              ring_wdata            = run_id_q;
              wr_idx_d              = idx_inc(wr_idx_q);
              res_d.previous_saved  = 1'b1;
              res_d.previous_thread = run_id_q;
            end
            run_id_d                = ring_rdata;
            run_valid_d             = 1'b1;
            flag_set                = 1'b1;
            res_d.dispatched_thread = ring_rdata;
            res_d.action = flag_rd ? rrts_pkg::ActResume : rrts_pkg::ActStart;
          end
        end
        default: begin
        end
      endcase
    end
    cnt_next          = ring_cnt(wr_idx_d, rd_idx_d);
    res_d.ready_count = rrts_pkg::IdW'(cnt_next);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      wr_idx_q       <= '0;
      rd_idx_q       <= '0;
      run_valid_q    <= 1'b0;
      run_id_q       <= '0;
      result_valid_q <= 1'b0;
      op_q           <= rrts_pkg::OpCreate;
      tid_q          <= '0;
      res_q          <= '0;
    end else begin
      result_valid_q <= exec;
      wr_idx_q       <= wr_idx_d;
      rd_idx_q       <= rd_idx_d;
      run_valid_q    <= run_valid_d;
      run_id_q       <= run_id_d;
      // latch the beat on accept, the result at the end of execute
      if (accept) begin
        op_q  <= operation_i;
        tid_q <= thread_id_i;
      end
      if (exec) begin
        res_q <= res_d;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign result_valid_o      = result_valid_q;
  assign action_o            = res_q.action;
  assign dispatched_thread_o = res_q.dispatched_thread;
  assign previous_saved_o    = res_q.previous_saved;
  assign previous_thread_o   = res_q.previous_thread;
  assign ready_count_o       = res_q.ready_count;

  `ASSERT_CLK(a_busy_after_start, (start && !busy) |=> busy, "accepted beat not executed")
  `ASSERT_CLK(a_strobe_after_exec, result_valid_q |-> $past(state_q == StExec), "stray strobe")
  `ASSERT_NEVER(a_ring_overfill, cnt_now >= CntW'(QUEUE_DEPTH), "ready ring overfilled")

endmodule

// ----- tb/sv/round_robin_thread_scheduler_top_test.sv -----
// self-checking testbench for the round-robin thread scheduler top level
// holds its own model of the ready ring; depends on rrts_pkg and the scheduler rtl
module round_robin_thread_scheduler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RingSlots = 64;
  localparam int unsigned ThreadSlots = 64;
  // operation code 3 has no name in the package, the block ignores it
  localparam logic [1:0] OpUnused = 2'd3;

  // model of the ready ring and running thread, one expected result per beat
  class result_scoreboard;
    logic [rrts_pkg::IdW-1:0] ring_ids [RingSlots];
    int unsigned              wr_slot;
    int unsigned              rd_slot;
    bit                       has_running;
    logic [rrts_pkg::IdW-1:0] running_id;
    bit                       was_started [ThreadSlots];
    rrts_pkg::result_t        expected_q [$];
    int unsigned              errors;

    function new();
      wr_slot = 0;
      rd_slot = 0;
      has_running = 1'b0;
      running_id = '0;
      errors = 0;
      foreach (was_started[i]) was_started[i] = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // work out the result of an accepted beat and advance the model
    function void note_beat(logic [1:0] op, logic [rrts_pkg::IdW-1:0] tid);
      rrts_pkg::result_t        want;
      logic [rrts_pkg::IdW-1:0] popped;
      int unsigned              fill;
      want = '0;
      case (op)
        rrts_pkg::OpCreate: begin
          if ((wr_slot + 1) % RingSlots == rd_slot) begin
            want.action = rrts_pkg::ActReject;
          end else begin
            ring_ids[wr_slot] = tid;
            wr_slot = (wr_slot + 1) % RingSlots;
            was_started[tid % ThreadSlots] = 1'b0;
            want.action = rrts_pkg::ActAccept;
          end
        end
        rrts_pkg::OpTick, rrts_pkg::OpExit: begin
          // an exit drops the running thread before scheduling
          if (op == rrts_pkg::OpExit) has_running = 1'b0;
          if (wr_slot != rd_slot) begin
            popped = ring_ids[rd_slot];
            rd_slot = (rd_slot + 1) % RingSlots;
            if (has_running) begin
              ring_ids[wr_slot] = running_id;
              wr_slot = (wr_slot + 1) % RingSlots;
              want.previous_saved = 1'b1;
              want.previous_thread = running_id;
            end
            running_id = popped;
            has_running = 1'b1;
            want.action = was_started[popped % ThreadSlots] ? rrts_pkg::ActResume
                                                            : rrts_pkg::ActStart;
            was_started[popped % ThreadSlots] = 1'b1;
            want.dispatched_thread = popped;
          end
        end
        default: ;
      endcase
      fill = (wr_slot + RingSlots - rd_slot) % RingSlots;
      want.ready_count = fill[rrts_pkg::IdW-1:0];
      expected_q.push_back(want);
    endfunction

    task check_result(rrts_pkg::result_t got);
      rrts_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected, action %0d", got.action));
        return;
      end
      want = expected_q.pop_front();
      if (got.action !== want.action)
        report($sformatf("action %0d, expected %0d", got.action, want.action));
      if (got.dispatched_thread !== want.dispatched_thread)
        report($sformatf("dispatched_thread %0d, expected %0d",
                         got.dispatched_thread, want.dispatched_thread));
      if (got.previous_saved !== want.previous_saved)
        report($sformatf("previous_saved %0b, expected %0b",
                         got.previous_saved, want.previous_saved));
      if (got.previous_thread !== want.previous_thread)
        report($sformatf("previous_thread %0d, expected %0d",
                         got.previous_thread, want.previous_thread));
      if (got.ready_count !== want.ready_count)
        report($sformatf("ready_count %0d, expected %0d", got.ready_count, want.ready_count));
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [1:0]               operation_i;
  logic [rrts_pkg::IdW-1:0] thread_id_i;
  logic                     result_valid_o;
  logic [2:0]               action_o;
  logic [rrts_pkg::IdW-1:0] dispatched_thread_o;
  logic                     previous_saved_o;
  logic [rrts_pkg::IdW-1:0] previous_thread_o;
  logic [rrts_pkg::IdW-1:0] ready_count_o;

  result_scoreboard sb;

  round_robin_thread_scheduler_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .operation_i         (operation_i),
    .thread_id_i         (thread_id_i),
    .result_valid_o      (result_valid_o),
    .action_o            (action_o),
    .dispatched_thread_o (dispatched_thread_o),
    .previous_saved_o    (previous_saved_o),
    .previous_thread_o   (previous_thread_o),
    .ready_count_o       (ready_count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // results are sampled at the edge that ends their strobe cycle, before any update lands
  always @(posedge clk_i) begin
    rrts_pkg::result_t got;
    if (rst_ni && result_valid_o && sb != null) begin
      got.action = action_o;
      got.dispatched_thread = dispatched_thread_o;
      got.previous_saved = previous_saved_o;
      got.previous_thread = previous_thread_o;
      got.ready_count = ready_count_o;
      sb.check_result(got);
    end
  end

  // present one beat and hold it until an edge sees start high with busy low
  task automatic send_beat(input logic [1:0] op, input logic [rrts_pkg::IdW-1:0] tid);
    start <= 1'b1;
    operation_i <= op;
    thread_id_i <= tid;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_beat(op, tid);
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // hold off the sender until the block has answered every beat
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // random beats with a weighted mix of operations; whatever is left of 100
  // after create, tick and exit goes to the unused code
  task automatic random_beats(input int unsigned n, input int unsigned w_create,
                              input int unsigned w_tick, input int unsigned w_exit,
                              input int unsigned gap_pct);
    int unsigned              pick;
    logic [1:0]               op;
    logic [rrts_pkg::IdW-1:0] tid;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < w_create) op = rrts_pkg::OpCreate;
      else if (pick < w_create + w_tick) op = rrts_pkg::OpTick;
      else if (pick < w_create + w_tick + w_exit) op = rrts_pkg::OpExit;
      else op = OpUnused;
      tid = $urandom_range(63);
      send_beat(op, tid);
      // bursts of idle cycles always leave the block back in its idle state before the next beat
      if ($urandom_range(99) < gap_pct) idle_cycles($urandom_range(1, 8));
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    operation_i <= rrts_pkg::OpCreate;
    thread_id_i <= '0;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty ring with nothing running, then a short round-robin walk
    send_beat(rrts_pkg::OpTick, 6'h3f);
    send_beat(rrts_pkg::OpExit, 6'h00);
    send_beat(OpUnused, 6'h2a);
    send_beat(rrts_pkg::OpCreate, 6'h00);
    send_beat(rrts_pkg::OpCreate, 6'h3f);
    send_beat(rrts_pkg::OpCreate, 6'h3f);    // duplicate id sits in the ring twice
    send_beat(rrts_pkg::OpTick, 6'h15);      // first thread starts, nothing to save
    send_beat(rrts_pkg::OpTick, 6'h2a);      // running thread saved, next one starts
    send_beat(rrts_pkg::OpTick, 6'h00);      // the duplicate copy resumes
    send_beat(rrts_pkg::OpExit, 6'h3f);      // running thread dropped, no save
    idle_cycles(3);
    send_beat(rrts_pkg::OpTick, 6'h15);
    send_beat(rrts_pkg::OpExit, 6'h2a);      // ring drains empty
    send_beat(rrts_pkg::OpTick, 6'h00);      // empty ring keeps the running thread
    send_beat(rrts_pkg::OpExit, 6'h3f);      // empty ring still drops the running thread
    send_beat(rrts_pkg::OpTick, 6'h00);
    send_beat(rrts_pkg::OpCreate, 6'h00);    // a re-created id starts over
    send_beat(rrts_pkg::OpCreate, 6'h2a);
    send_beat(rrts_pkg::OpCreate, 6'h15);
    send_beat(rrts_pkg::OpTick, 6'h3f);
    send_beat(rrts_pkg::OpExit, 6'h00);
    send_beat(OpUnused, 6'h15);
    wait_drained();

    // random: balanced, then create-heavy until the ring is full and rejects,
    // then exit-heavy so empty-ring ticks and exits come up often
    random_beats(400, 40, 35, 22, 30);
    random_beats(300, 80, 12, 6, 30);
    wait_drained();
    random_beats(300, 15, 35, 48, 50);
    random_beats(250, 40, 35, 22, 0);
    random_beats(250, 80, 12, 6, 20);
    // no idling from here to the end
    random_beats(250, 40, 35, 22, 0);

    start <= 1'b0;
    for (int i = 0; i < 200 && sb.pending() != 0; i++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("[round_robin_thread_scheduler_top] OK");
    end else begin
      $display("[round_robin_thread_scheduler_top] ERROR");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #2000000;
    $display("[round_robin_thread_scheduler_top] ERROR");
    $finish;
  end

endmodule
